[sv/png_row_filter_encoder_unit_defines.svh]
// Assertion macros for the PNG row filter encoder unit.
// Used by png_row_filter_encoder_unit.sv; depends on nothing else.
`ifndef PNG_ROW_FILTER_ENCODER_UNIT_DEFINES_SVH
`define PNG_ROW_FILTER_ENCODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prfe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PRFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prfe assertion failed");

`endif

[sv/prfe_pkg.sv]
// Package for the PNG row filter encoder unit: filter codes, register codes,
// register widths and reset values, the stage type and the Paeth predictor.
// Depends on nothing.
`default_nettype none

package prfe_pkg;

    localparam int ROW_BYTES_W     = 14;
    localparam int PIXEL_BYTES_W   = 4;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic [ROW_BYTES_W-1:0]   ROW_BYTES_RESET   = 14'd1;
    localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RESET = 4'd4;

    // Register select taken from paddr[2].
    localparam logic REG_ROW_BYTES   = 1'b0;
    localparam logic REG_PIXEL_BYTES = 1'b1;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_SUB   = 3'd1,
        MODE_UP    = 3'd2,
        MODE_AVG   = 3'd3,
        MODE_PAETH = 3'd4
    } filter_mode_t;

    // Item held between the line memory read and the output register.
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] raw;
        logic       no_up;
        logic       has_left;
        logic [7:0] left;
        logic       last;
    } stage_t;

    function automatic logic [7:0] paeth_predict(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] c
    );
        logic signed [10:0] pa_s;
        logic signed [10:0] pb_s;
        logic signed [10:0] pc_s;
        logic [9:0]         pa;
        logic [9:0]         pb;
        logic [9:0]         pc;
        logic [7:0]         pick;
        pa_s = $signed({3'b000, b}) - $signed({3'b000, c});
        pb_s = $signed({3'b000, a}) - $signed({3'b000, c});
        pc_s = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        pa = pa_s[10] ? 10'(-pa_s) : pa_s[9:0];
        pb = pb_s[10] ? 10'(-pb_s) : pb_s[9:0];
        pc = pc_s[10] ? 10'(-pc_s) : pc_s[9:0];
        if (pa <= pb && pa <= pc)
        begin
            pick = a;
        end
        else if (pb <= pc)
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

[sv/png_row_filter_encoder_unit.sv]
// Pipeline: an accepted item passes through the working stage register and then the
// output register; the working stage stalls while the output register is full and not taken.
// Throughput: one item per cycle while results are taken; the line memory is read and written for
// each item in its accept cycle and its read data is registered at the accept.
// Reset: rst_n clears control state, both neighbor windows, the column and
// the registers; line memory contents are undefined until written.
// PNG row filter encoder: top level, holds the line memory and the pipeline.
// Depends on prfe_pkg and png_row_filter_encoder_unit_defines.svh.
`default_nettype none
`include "png_row_filter_encoder_unit_defines.svh"

module png_row_filter_encoder_unit
    import prfe_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // APB-style configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // Input item channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [2:0]            mode,
    input  wire logic [7:0]            raw_byte,
    input  wire logic                  no_prior_row,
    // Result item channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [7:0]            filtered_byte,
    output logic                       row_end
);

    // Column index addresses the line memory directly. The length compare
    // is done wide enough to hold both the register and the memory depth.
    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int LEN_W  = (COL_W + 1 > ROW_BYTES_W) ? COL_W + 1 : ROW_BYTES_W;
    localparam int WIN_IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // ------------------------------------------------------------------
    // Configuration registers. Writes happen only while the block is idle; the user
    // is bound to this and the block itself does not enforce it. The pipeline uses the live register values.
    // ------------------------------------------------------------------
    logic [ROW_BYTES_W-1:0]   row_bytes_reg;
    logic [PIXEL_BYTES_W-1:0] pixel_bytes_reg;
    logic                     cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg   <= ROW_BYTES_RESET;
            pixel_bytes_reg <= PIXEL_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ROW_BYTES)
            begin
                row_bytes_reg <= pwdata[ROW_BYTES_W-1:0];
            end
            else
            begin
                pixel_bytes_reg <= pwdata[PIXEL_BYTES_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PIXEL_BYTES)
        begin
            prdata = APB_DATA_W'(pixel_bytes_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(row_bytes_reg);
        end
    end

    // Out-of-range register values are clamped: a length or pixel size of
    // zero acts as one, and values above the supported maximum saturate.
    logic [LEN_W-1:0]         row_len;
    logic [PIXEL_BYTES_W-1:0] pix_len;
    logic [WIN_IW-1:0]        win_sel;

    always_comb
    begin
        if (row_bytes_reg == '0)
        begin
            row_len = LEN_W'(1);
        end
        else if (LEN_W'(row_bytes_reg) > LEN_W'(MAX_ROW_BYTES))
        begin
            row_len = LEN_W'(MAX_ROW_BYTES);
        end
        else
        begin
            row_len = LEN_W'(row_bytes_reg);
        end

        if (pixel_bytes_reg == '0)
        begin
            pix_len = PIXEL_BYTES_W'(1);
        end
        else if (pixel_bytes_reg > PIXEL_BYTES_W'(MAX_PIXEL_BYTES))
        begin
            pix_len = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
        end
        else
        begin
            pix_len = pixel_bytes_reg;
        end

        win_sel = WIN_IW'(pix_len - PIXEL_BYTES_W'(1));
    end

    // ------------------------------------------------------------------
    // Handshake. The pipeline has one working stage, where the line memory
    // data arrives, and an output register. A new item enters whenever the
    // working stage is empty or moves on in the same cycle.
    // ------------------------------------------------------------------
    logic   stage_valid_reg;
    logic   stage_valid_next;
    stage_t stage_reg;
    stage_t stage_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   stage_adv;
    logic   in_fire;

    assign stage_adv = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || stage_adv;
    assign in_fire   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Column tracking and the left window of raw bytes of this row. Both
    // advance as the item is accepted.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [LEN_W-1:0] col_plus1;
    logic             row_last;
    logic             has_left;
    logic [7:0]       left_win_reg [MAX_PIXEL_BYTES];

    always_comb
    begin
        col_plus1 = LEN_W'(col_reg) + LEN_W'(1);
        row_last  = (col_plus1 >= row_len);
        has_left  = (LEN_W'(col_reg) >= LEN_W'(pix_len));
        col_next  = row_last ? '0 : col_plus1[COL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            begin
                left_win_reg[k] <= '0;
            end
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--)
            begin
                left_win_reg[k] <= left_win_reg[k - 1];
            end
            left_win_reg[0] <= raw_byte;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: the raw bytes of the previous row by column. Each item
    // reads its column and overwrites it with its own raw byte in the same
    // cycle; the read returns the old contents. The read data only changes
    // on accept, so it holds while the working stage is stalled.
    // ------------------------------------------------------------------
    logic [7:0] line_mem [MAX_ROW_BYTES];
    logic [7:0] upper_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            line_mem[col_reg] <= raw_byte;
            upper_rd_reg      <= line_mem[col_reg];
        end
    end

    // ------------------------------------------------------------------
    // Working stage.
    // ------------------------------------------------------------------
    always_comb
    begin
        stage_next.mode     = mode;
        stage_next.raw      = raw_byte;
        stage_next.no_up    = no_prior_row;
        stage_next.has_left = has_left;
        stage_next.left     = has_left ? left_win_reg[win_sel] : 8'd0;
        stage_next.last     = row_last;

        if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_adv)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg <= stage_next;
        end
    end

    // The upper-left window shifts in the upper byte (zero when there is
    // no prior row) as each item leaves the working stage, so the next item
    // there always sees the window of all earlier items.
    logic [7:0] upper_win_reg [MAX_PIXEL_BYTES];
    logic [7:0] up_b;
    logic [7:0] up_c;
    logic [8:0] avg_sum;
    logic [7:0] pred;
    logic [7:0] filtered_next;

    always_comb
    begin
        up_b    = stage_reg.no_up ? 8'd0 : upper_rd_reg;
        up_c    = (stage_reg.has_left && !stage_reg.no_up) ? upper_win_reg[win_sel] : 8'd0;
        avg_sum = {1'b0, stage_reg.left} + {1'b0, up_b};

        case (filter_mode_t'(stage_reg.mode))
            MODE_SUB:   pred = stage_reg.left;
            MODE_UP:    pred = up_b;
            MODE_AVG:   pred = avg_sum[8:1];
            MODE_PAETH: pred = paeth_predict(stage_reg.left, up_b, up_c);
            default:    pred = 8'd0;
        endcase

        filtered_next = stage_reg.raw - pred;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++)
            begin
                upper_win_reg[k] <= '0;
            end
        end
        else if (stage_adv)
        begin
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--)
            begin
                upper_win_reg[k] <= upper_win_reg[k - 1];
            end
            upper_win_reg[0] <= up_b;
        end
    end

    // ------------------------------------------------------------------
    // Output register. It takes the next result in the cycle its current
    // result is taken, so the input side keeps moving.
    // ------------------------------------------------------------------
    logic [7:0] filtered_reg;
    logic       row_end_reg;

    always_comb
    begin
        if (stage_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            filtered_reg <= filtered_next;
            row_end_reg  <= stage_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign filtered_byte = filtered_reg;
    assign row_end       = row_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PRFE_ASSERT_NEXT(a_col_step, clk, rst_n, in_fire && !row_last,
        col_reg == $past(col_plus1[COL_W-1:0]))
    `PRFE_ASSERT_NEXT(a_col_wrap, clk, rst_n, in_fire && row_last, col_reg == '0)
    `PRFE_ASSERT_NEXT(a_stall_hold, clk, rst_n, stage_valid_reg && !stage_adv,
        stage_valid_reg && $stable(up_b))
    `PRFE_ASSERT_SAME(a_out_from_stage, clk, rst_n, $rose(out_valid_reg), $past(stage_adv))

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for png_row_filter_encoder_unit: random and directed image rows
// go in, and a scoreboard class predicts each filtered byte and its row_end flag.
// Depends on prfe_pkg and the RTL of the unit under test.
`default_nettype none

module tb
    import prfe_pkg::*;
;

    localparam int MAX_COLS     = 8192;
    localparam int MAX_PIX      = 8;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 80;

    // Filter codes above Paeth are not in the package enum; the unit passes them through.
    localparam logic [2:0] MODE_RSVD_LO  = 3'd5;
    localparam logic [2:0] MODE_RSVD_MID = 3'd6;
    localparam logic [2:0] MODE_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic [7:0] fb;
        logic       last;
    } filtered_t;

    // Scoreboard: it mirrors the line store, both neighbor windows, the column
    // and the two registers, and keeps the filtered bytes that are still due.
    class filter_predictor;
        bit [7:0]              upper_row [MAX_COLS];
        bit                    seen [MAX_COLS];
        bit [7:0]              left_hist [MAX_PIX];
        bit [7:0]              upleft_hist [MAX_PIX];
        int unsigned           column;
        logic [ROW_BYTES_W-1:0]   row_len_reg;
        logic [PIXEL_BYTES_W-1:0] pix_reg;
        filtered_t             due [$];
        int                    errors;

        function void clear();
            foreach (upper_row[i])
            begin
                upper_row[i] = 8'h00;
                seen[i] = 1'b0;
            end
            foreach (left_hist[i])
            begin
                left_hist[i] = 8'h00;
                upleft_hist[i] = 8'h00;
            end
            column = 0;
            row_len_reg = ROW_BYTES_RESET;
            pix_reg = PIXEL_BYTES_RESET;
            due.delete();
            errors = 0;
        endfunction

        function void set_register(logic sel, logic [APB_DATA_W-1:0] v);
            if (sel == REG_ROW_BYTES)
            begin
                row_len_reg = v[ROW_BYTES_W-1:0];
            end
            else
            begin
                pix_reg = v[PIXEL_BYTES_W-1:0];
            end
        endfunction

        // True when the current column holds a byte from an earlier row.
        function bit upper_known();
            return seen[column];
        endfunction

        function bit [7:0] paeth_guess(bit [7:0] a, bit [7:0] b, bit [7:0] c);
            int da;
            int db;
            int dc;
            da = int'(b) - int'(c);
            db = int'(a) - int'(c);
            dc = int'(a) + int'(b) - 2 * int'(c);
            if (da < 0) da = -da;
            if (db < 0) db = -db;
            if (dc < 0) dc = -dc;
            if (da <= db && da <= dc)
            begin
                return a;
            end
            if (db <= dc)
            begin
                return b;
            end
            return c;
        endfunction

        function void absorb(logic [2:0] m, logic [7:0] r, logic np);
            int unsigned len;
            int unsigned bpp;
            int unsigned col;
            bit [7:0]    a;
            bit [7:0]    b;
            bit [7:0]    c;
            bit [7:0]    guess;
            filtered_t   e;
            len = (row_len_reg == 0) ? 1 : ((row_len_reg > MAX_COLS) ? MAX_COLS : row_len_reg);
            bpp = (pix_reg == 0) ? 1 : ((pix_reg > MAX_PIX) ? MAX_PIX : pix_reg);
            col = column;
            a = 8'h00;
            b = 8'h00;
            c = 8'h00;
            if (!np)
            begin
                b = upper_row[col];
            end
            if (col >= bpp)
            begin
                a = left_hist[bpp-1];
                if (!np)
                begin
                    c = upleft_hist[bpp-1];
                end
            end
            case (m)
                MODE_SUB:   guess = a;
                MODE_UP:    guess = b;
                MODE_AVG:   guess = 8'((int'(a) + int'(b)) >> 1);
                MODE_PAETH: guess = paeth_guess(a, b, c);
                default:    guess = 8'h00;
            endcase
            for (int k = MAX_PIX - 1; k > 0; k--)
            begin
                left_hist[k] = left_hist[k-1];
                upleft_hist[k] = upleft_hist[k-1];
            end
            left_hist[0] = r;
            upleft_hist[0] = b;
            upper_row[col] = r;
            seen[col] = 1'b1;
            e.last = (col + 1 >= len);
            e.fb = r - guess;
            column = e.last ? 0 : col + 1;
            due.push_back(e);
        endfunction

        function void flag(string what);
            $display("%0t: %s", $time, what);
            errors++;
        endfunction

        function void compare(logic [7:0] fb, logic re);
            filtered_t e;
            if (due.size() == 0)
            begin
                flag($sformatf("unexpected byte: expected none, actual %h row_end %b", fb, re));
                return;
            end
            e = due.pop_front();
            if (fb !== e.fb)
            begin
                flag($sformatf("filtered_byte: expected %h, actual %h", e.fb, fb));
            end
            if (re !== e.last)
            begin
                flag($sformatf("row_end: expected %b, actual %b", e.last, re));
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            mode = 3'd0;
    logic [7:0]            raw_byte = 8'h00;
    logic                  no_prior_row = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            filtered_byte;
    logic                  row_end;

    filter_predictor board;

    // Sender and receiver pacing. These flags are set with nonblocking
    // assignments so that the receiver always sees the value from before the edge.
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned sent = 0;
    int unsigned cycles = 0;

    // Row-level choices for the random stimulus, renewed at the start of each row.
    logic [2:0]  row_mode;
    bit          row_np;
    int unsigned row_shape;

    png_row_filter_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .raw_byte      (raw_byte),
        .no_prior_row  (no_prior_row),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .filtered_byte (filtered_byte),
        .row_end       (row_end)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: it checks every result item taken at this edge, then decides
    // out_ready for the next cycle. Once during the run it holds off for a long
    // stretch so that the pipeline fills and in_ready drops while items wait.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.compare(filtered_byte, row_end);
        end
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (steady)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= 13);
        end
    end

    // Offers one item and waits for it to be taken. A column that has never been
    // written has no upper byte to read, so such an item is always sent as a
    // first row. After the item is taken, the sender sometimes drops in_valid and goes idle.
    task automatic offer(input logic [2:0] m, input logic [7:0] r, input logic np);
        logic np_eff;
        np_eff = np | !board.upper_known();
        in_valid <= 1'b1;
        mode <= m;
        raw_byte <= r;
        no_prior_row <= np_eff;
        // The long receiver hold-off starts while this item is on offer, so the
        // sender keeps offering items all through it.
        if (sent == 330)
        begin
            hold_req <= 1'b1;
        end
        do
            @(posedge clk);
        while (!in_ready);
        board.absorb(m, r, np_eff);
        sent++;
        // A stretch in the middle of the run has no idling at all; the long
        // receiver hold-off falls inside it.
        steady <= (sent >= 300 && sent < 520);
        if (!steady && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // One APB write: a setup phase, then an access phase that writes the register.
    task automatic write_reg(input logic sel, input logic [APB_DATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_register(sel, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only while the unit is empty: the input is dropped, every
    // due byte has come out, and a drain wait covers the pipeline. The row
    // may still be open, in which case the column carries over to the new geometry.
    task automatic set_geometry(input int unsigned len, input int unsigned bpp);
        in_valid <= 1'b0;
        while (board.due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_ROW_BYTES, APB_DATA_W'(len));
        write_reg(REG_PIXEL_BYTES, APB_DATA_W'(bpp));
    endtask

    // Random item for the current position. Most rows look like real images:
    // one filter for the whole row and a real row above. Some rows mix filters
    // byte by byte or flip no_prior_row mid-row. Raw bytes are partly smooth
    // against the row above so that the Paeth predictor picks every neighbor.
    task automatic pick_item(output logic [2:0] m, output logic [7:0] r, output logic np);
        int unsigned roll;
        if (board.column == 0)
        begin
            if ($urandom_range(99) < 90)
            begin
                row_mode = 3'($urandom_range(MODE_NONE, MODE_PAETH));
            end
            else
            begin
                row_mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
            end
            row_shape = $urandom_range(99);
            row_np = ($urandom_range(99) < 12);
        end
        m = (row_shape < 15) ? 3'($urandom_range(MODE_NONE, MODE_RSVD_HI)) : row_mode;
        np = (row_shape >= 90) ? 1'($urandom_range(1)) : row_np;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            r = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        else if (roll < 40)
        begin
            r = board.upper_row[board.column] + 8'($urandom_range(6)) - 8'd3;
        end
        else
        begin
            r = 8'($urandom);
        end
    endtask

    initial
    begin
        int unsigned done_random;
        int unsigned count;
        int unsigned len;
        int unsigned bpp;
        int unsigned phase;
        logic [2:0]  m;
        logic [7:0]  r;
        logic        np;

        board = new();
        board.clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset geometry: every row is one byte long, so
        // each filter sees only the upper neighbor, and the codes above Paeth pass through.
        offer(MODE_NONE, 8'h00, 1'b1);
        offer(MODE_SUB, 8'hFF, 1'b0);
        offer(MODE_UP, 8'h00, 1'b0);
        offer(MODE_AVG, 8'hFF, 1'b0);
        offer(MODE_PAETH, 8'h80, 1'b0);
        offer(MODE_UP, 8'h7F, 1'b1);
        offer(MODE_RSVD_LO, 8'hAA, 1'b0);
        offer(MODE_RSVD_MID, 8'h55, 1'b0);
        offer(MODE_RSVD_HI, 8'hFF, 1'b1);

        // Four-byte rows of two-byte pixels: a first row, a Paeth row over it,
        // then a row that mixes filters and drops the row above for one byte only.
        set_geometry(4, 2);
        offer(MODE_PAETH, 8'hFF, 1'b1);
        offer(MODE_PAETH, 8'h00, 1'b1);
        offer(MODE_PAETH, 8'hFF, 1'b1);
        offer(MODE_PAETH, 8'h01, 1'b1);
        offer(MODE_PAETH, 8'h00, 1'b0);
        offer(MODE_PAETH, 8'hFF, 1'b0);
        offer(MODE_PAETH, 8'h80, 1'b0);
        offer(MODE_PAETH, 8'h7F, 1'b0);
        offer(MODE_SUB, 8'h10, 1'b0);
        offer(MODE_UP, 8'hF0, 1'b1);
        offer(MODE_AVG, 8'hFF, 1'b0);
        offer(MODE_PAETH, 8'h00, 1'b0);

        // Random part in phases. The first phases hit the register extremes:
        // zero and the top of the field for both, and the full line store. Long
        // rows get only a few bytes each, so the next phase usually cuts them short mid-row.
        done_random = 0;
        phase = 0;
        while (done_random < RANDOM_ITEMS)
        begin
            case (phase)
                0: begin len = 0;     bpp = 0;  end
                1: begin len = 16383; bpp = 15; end
                2: begin len = 8192;  bpp = 8;  end
                3: begin len = 3;     bpp = 1;  end
                default:
                begin
                    count = $urandom_range(99);
                    if (count < 75)
                    begin
                        len = $urandom_range(1, 24);
                    end
                    else if (count < 88)
                    begin
                        len = $urandom_range(25, 200);
                    end
                    else
                    begin
                        len = $urandom_range(16383);
                    end
                    bpp = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(15);
                end
            endcase
            set_geometry(len, bpp);
            count = (len > 200) ? $urandom_range(8, 30) : $urandom_range(30, 60);
            repeat (count)
            begin
                pick_item(m, r, np);
                offer(m, r, np);
                done_random++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (board.due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.due.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
